### sv/kpmh_pkg.sv
// Shared constants, types and codes for the k-partition MinHash signature block.
package kpmh_pkg;

  localparam int NUM_PARTITIONS = 64;
  localparam int VOCAB_SIZE     = 50257;

  localparam int TOK_W      = 16;
  localparam int HASH_W     = 30;
  localparam int PART_W     = 6;
  localparam int PROD_W     = TOK_W + HASH_W;
  localparam int CFG_IDX_W  = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam longint HASH_PRIME_L = 998244353;
  localparam longint HASH_RANGE_L = (HASH_PRIME_L / NUM_PARTITIONS) * NUM_PARTITIONS;
  localparam longint PART_WIDTH_L = HASH_RANGE_L / NUM_PARTITIONS;

  localparam logic [HASH_W-1:0] HASH_PRIME = HASH_W'(HASH_PRIME_L);
  localparam logic [HASH_W-1:0] HASH_RANGE = HASH_W'(HASH_RANGE_L);
  localparam logic [HASH_W-1:0] PART_WIDTH = HASH_W'(PART_WIDTH_L);

  // 2^HASH_W mod prime, used to fold the high bits back down
  localparam logic [PROD_W-1:0] FOLD_C = PROD_W'((longint'(1) << HASH_W) % HASH_PRIME_L);
  localparam int NUM_FOLDS = 6;

  // partition = v / PART_WIDTH via reciprocal, estimate is low by at most one
  localparam int     RECIP_SH = HASH_W + 6;
  localparam longint RECIP_L  = (longint'(1) << RECIP_SH) / PART_WIDTH_L;
  localparam int     RECIP_W  = $clog2(RECIP_L + 1);
  localparam int     REC_W    = HASH_W + RECIP_W;
  localparam int     Q_W      = PART_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  localparam int NUM_STAGES = NUM_FOLDS + 6;

  localparam logic [HASH_W-1:0] SENTINEL  = '1;
  localparam logic [TOK_W-1:0]  EMPTY_TOK = TOK_W'(VOCAB_SIZE);
  localparam logic [PART_W-1:0] LAST_PART = PART_W'(NUM_PARTITIONS - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_HASH_MULT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HASH_ADD  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [HASH_W-1:0] mult;
    logic [HASH_W-1:0] add;
  } kpmh_cfg_t;

  typedef struct packed {
    logic              last;
    logic [TOK_W-1:0]  tok;
    logic [PART_W-1:0] part;
    logic [HASH_W-1:0] hash;
  } kpmh_item_t;

  typedef struct packed {
    logic              last;
    logic [TOK_W-1:0]  tok;
    logic [PART_W-1:0] part;
  } kpmh_res_t;

endpackage

### sv/kpmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kpmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/kpmh_front.sv
// Front end: hash pipeline computing the reduced hash and partition of each token.
module kpmh_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kpmh_pkg::kpmh_cfg_t           cfg,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic [kpmh_pkg::TOK_W-1:0]    in_tok,
  input  logic                          in_last,
  output logic                          push_vld,
  input  logic                          push_rdy,
  output kpmh_pkg::kpmh_item_t          push_item
);

  localparam int NS   = kpmh_pkg::NUM_STAGES;
  localparam int NF   = kpmh_pkg::NUM_FOLDS;
  localparam int HW   = kpmh_pkg::HASH_W;
  localparam int PW   = kpmh_pkg::PROD_W;
  localparam int SA   = NF + 1;
  localparam int SB   = NF + 2;
  localparam int SC   = NF + 3;
  localparam int SD   = NF + 4;
  localparam int SE   = NF + 5;

  logic                       vld_r  [NS];
  logic [kpmh_pkg::TOK_W-1:0] tok_r  [NS];
  logic                       last_r [NS];

  logic [PW-1:0]              fold_r   [NF+1];
  logic [PW-1:0]              fold_nxt [NF+1];
  logic [HW-1:0]              h_r, h_nxt;
  logic [HW-1:0]              vb_r, vb_nxt;
  logic [HW-1:0]              vc_r, vd_r, ve_r;
  logic [kpmh_pkg::REC_W-1:0] rec_r, rec_nxt;
  logic [kpmh_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [HW-1:0]              qpw_r, qpw_nxt;
  logic [kpmh_pkg::PART_W-1:0] part_r, part_nxt;

  logic                       en;
  logic [HW:0]                red;
  logic [HW-1:0]              rem;
  logic [kpmh_pkg::Q_W-1:0]   qfix;

  assign en     = !vld_r[NS-1] || push_rdy;
  assign in_rdy = en;

  always_comb begin
    fold_nxt[0] = PW'(in_tok) * PW'(cfg.mult) + PW'(cfg.add);
    for (int i = 1; i <= NF; i++) begin
      fold_nxt[i] = fold_r[i-1][PW-1:HW] * kpmh_pkg::FOLD_C + PW'(fold_r[i-1][HW-1:0]);
    end
    red   = fold_r[NF][HW:0];
    h_nxt = (red >= {1'b0, kpmh_pkg::HASH_PRIME}) ?
            HW'(red - {1'b0, kpmh_pkg::HASH_PRIME}) : red[HW-1:0];
    vb_nxt  = (h_r >= kpmh_pkg::HASH_RANGE) ? h_r - kpmh_pkg::HASH_RANGE : h_r;
    rec_nxt = kpmh_pkg::REC_W'(vb_r) * kpmh_pkg::REC_W'(kpmh_pkg::RECIP);
    q_nxt   = rec_r[kpmh_pkg::RECIP_SH + kpmh_pkg::Q_W - 1:kpmh_pkg::RECIP_SH];
    qpw_nxt = HW'(q_nxt * kpmh_pkg::PART_WIDTH);
    rem     = vd_r - qpw_r;
    qfix    = (rem >= kpmh_pkg::PART_WIDTH) ? q_r + kpmh_pkg::Q_W'(1) : q_r;
    part_nxt = (qfix >= kpmh_pkg::Q_W'(kpmh_pkg::NUM_PARTITIONS)) ?
               kpmh_pkg::LAST_PART : qfix[kpmh_pkg::PART_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < NS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
    if (en) begin
      tok_r[0]  <= in_tok;
      last_r[0] <= in_last;
      for (int s = 1; s < NS; s++) begin
        tok_r[s]  <= tok_r[s-1];
        last_r[s] <= last_r[s-1];
      end
      for (int i = 0; i <= NF; i++) begin
        fold_r[i] <= fold_nxt[i];
      end
      h_r    <= h_nxt;
      vb_r   <= vb_nxt;
      vc_r   <= vb_r;
      rec_r  <= rec_nxt;
      vd_r   <= vc_r;
      q_r    <= q_nxt;
      qpw_r  <= qpw_nxt;
      ve_r   <= vd_r;
      part_r <= part_nxt;
    end
  end

  assign push_vld       = vld_r[SE];
  assign push_item.last = last_r[SE];
  assign push_item.tok  = tok_r[SE];
  assign push_item.part = part_r;
  assign push_item.hash = ve_r;

  // stage map: 0 product, 1..NF folds, SA prime, SB range, SC recip, SD q, SE part
  logic unused_idx;
  assign unused_idx = (SA < SB) && (SC < SD);

endmodule

### sv/kpmh_fifo.sv
// Short queue between the hash front end and the table back end.
module kpmh_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_vld,
  output logic                 push_rdy,
  input  kpmh_pkg::kpmh_item_t push_item,
  output logic                 pop_vld,
  input  logic                 pop,
  output kpmh_pkg::kpmh_item_t pop_item
);

  localparam int AW = kpmh_pkg::FIFO_AW;

  kpmh_pkg::kpmh_item_t mem_r [kpmh_pkg::FIFO_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_rdy = cnt_r != (AW+1)'(kpmh_pkg::FIFO_DEPTH);
  assign pop_vld  = cnt_r != '0;
  assign pop_item = mem_r[rp_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop && pop_vld;

  always_comb begin
    wp_nxt  = do_push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

### sv/kpmh_back.sv
// Back end: per-partition minimum tables, update with bypass, signature readout.
module kpmh_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld,
  output logic                 item_pop,
  input  kpmh_pkg::kpmh_item_t item,
  output logic                 res_vld,
  input  logic                 res_rdy,
  output kpmh_pkg::kpmh_res_t  res
);

  localparam int HW = kpmh_pkg::HASH_W;
  localparam int TW = kpmh_pkg::TOK_W;
  localparam int NP = kpmh_pkg::NUM_PARTITIONS;
  localparam int AW = kpmh_pkg::PART_W;

  typedef enum logic [1:0] {ST_RUN, ST_EMIT_RD, ST_EMIT_WAIT} st_t;

  st_t                  state_r, state_nxt;
  logic [NP-1:0]        valid_r, valid_nxt;
  logic                 b_vld_r, b_vld_nxt;
  kpmh_pkg::kpmh_item_t b_r;
  logic                 wr_vld_r, wr_vld_nxt;
  logic [AW-1:0]        wr_addr_r;
  logic [HW+TW-1:0]     wr_data_r;
  logic [AW-1:0]        e_r, e_nxt;
  logic                 out_vld_r, out_vld_nxt;
  kpmh_pkg::kpmh_res_t  out_r, out_nxt;

  logic                 we;
  logic [AW-1:0]        raddr;
  logic [HW+TW-1:0]     wdata, rdata, cur;
  logic                 slot_free;

  kpmh_ram #(.WIDTH(HW + TW), .DEPTH(NP)) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (b_r.part),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign slot_free = !out_vld_r || res_rdy;
  assign item_pop  = (state_r == ST_RUN) && item_vld && !(b_vld_r && b_r.last);
  assign raddr     = (state_r == ST_RUN) ? item.part : e_r;
  assign wdata     = {b_r.hash, b_r.tok};

  always_comb begin
    if (wr_vld_r && (wr_addr_r == b_r.part)) begin
      cur = wr_data_r;
    end else if (valid_r[b_r.part]) begin
      cur = rdata;
    end else begin
      cur = {kpmh_pkg::SENTINEL, kpmh_pkg::EMPTY_TOK};
    end
    we = (state_r == ST_RUN) && b_vld_r && (b_r.hash < cur[HW+TW-1:TW]);

    state_nxt   = state_r;
    valid_nxt   = valid_r;
    b_vld_nxt   = item_pop;
    wr_vld_nxt  = we;
    e_nxt       = e_r;
    out_vld_nxt = out_vld_r && !res_rdy;
    out_nxt     = out_r;

    if (we) begin
      valid_nxt[b_r.part] = 1'b1;
    end

    case (state_r)
      ST_RUN: begin
        if (b_vld_r && b_r.last) begin
          state_nxt = ST_EMIT_RD;
          e_nxt     = '0;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_nxt.part = e_r;
          out_nxt.tok  = valid_r[e_r] ? rdata[TW-1:0] : kpmh_pkg::EMPTY_TOK;
          out_nxt.last = (e_r == kpmh_pkg::LAST_PART);
          if (e_r == kpmh_pkg::LAST_PART) begin
            state_nxt = ST_RUN;
            valid_nxt = '0;
          end else begin
            e_nxt     = e_r + AW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      valid_r   <= '0;
      b_vld_r   <= 1'b0;
      wr_vld_r  <= 1'b0;
      e_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      b_vld_r   <= b_vld_nxt;
      wr_vld_r  <= wr_vld_nxt;
      e_r       <= e_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (item_pop) begin
      b_r <= item;
    end
    wr_addr_r <= b_r.part;
    wr_data_r <= wdata;
    out_r     <= out_nxt;
  end

  assign res_vld = out_vld_r;
  assign res     = out_r;

endmodule

### sv/k_partition_minhash_signature.sv
// Top level of the k-partition MinHash signature block.
// Tokens enter one per cycle unless the queue back-pressures the 12-stage hash
// pipeline (universal hash, modular folding, partition by reciprocal) that feeds
// a 4-word queue. The table end updates one token per cycle, except while a
// signature is pending or read out, with a read-compare-write on a simple dual-port
// table and a one-deep write bypass. A token with tlast set starts the readout of all
// 64 partitions; each result word passes a table read, then the output register,
// and waits out any output stalls; tokens keep entering the hash pipeline until
// the queue fills. Configuration writes are taken every cycle.
module k_partition_minhash_signature (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kpmh_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] token
  input  logic                               in_tlast,   // seq_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kpmh_pkg::OUT_DATA_W-1:0]    out_tdata,  // [5:0] part_index, [21:6] sig_token
  output logic                               out_tlast,  // last_part
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kpmh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kpmh_pkg::HASH_W-1:0]        cfg_data
);

  kpmh_pkg::kpmh_cfg_t  cfg_r, cfg_nxt;
  logic                 push_vld, push_rdy, pop_vld, pop;
  kpmh_pkg::kpmh_item_t push_item, pop_item;
  kpmh_pkg::kpmh_res_t  res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        kpmh_pkg::REG_HASH_MULT: cfg_nxt.mult = cfg_data;
        kpmh_pkg::REG_HASH_ADD:  cfg_nxt.add  = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mult <= kpmh_pkg::HASH_W'(1);
      cfg_r.add  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kpmh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_vld    (in_tvalid),
    .in_rdy    (in_tready),
    .in_tok    (in_tdata[kpmh_pkg::TOK_W-1:0]),
    .in_last   (in_tlast),
    .push_vld  (push_vld),
    .push_rdy  (push_rdy),
    .push_item (push_item)
  );

  kpmh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_rdy  (push_rdy),
    .push_item (push_item),
    .pop_vld   (pop_vld),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  kpmh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (pop_vld),
    .item_pop (pop),
    .item     (pop_item),
    .res_vld  (out_tvalid),
    .res_rdy  (out_tready),
    .res      (res)
  );

  assign out_tdata = kpmh_pkg::OUT_DATA_W'({res.tok, res.part});
  assign out_tlast = res.last;

endmodule

### sv/kpmh_checker.sv
// Port-level checker for the signature block, bound to the top level.
module kpmh_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [kpmh_pkg::IN_DATA_W-1:0] in_tdata,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [kpmh_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [kpmh_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [kpmh_pkg::HASH_W-1:0]    cfg_data
);

  localparam int PB = kpmh_pkg::PART_W;
  localparam int DB = kpmh_pkg::PART_W + kpmh_pkg::TOK_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_last_part: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[PB-1:0] == kpmh_pkg::LAST_PART)))
    else $error("tlast does not match final partition");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[kpmh_pkg::OUT_DATA_W-1:DB] == '0)
    else $error("tdata padding not zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  logic unused_ports;
  assign unused_ports = ^{in_tvalid, in_tready, in_tdata, in_tlast,
                          cfg_valid, cfg_ready, cfg_index, cfg_data};

endmodule

bind k_partition_minhash_signature kpmh_checker u_kpmh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);

### tb/sv/k_partition_minhash_signature_tb.sv
// Self-checking testbench for the k-partition MinHash signature block.
module k_partition_minhash_signature_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PARTITIONS = kpmh_pkg::NUM_PARTITIONS;
  localparam int VOCAB_SIZE     = kpmh_pkg::VOCAB_SIZE;
  localparam int TOK_W          = kpmh_pkg::TOK_W;
  localparam int HASH_W         = kpmh_pkg::HASH_W;
  localparam int PART_W         = kpmh_pkg::PART_W;
  localparam int CFG_IDX_W      = kpmh_pkg::CFG_IDX_W;
  localparam int IN_DATA_W      = kpmh_pkg::IN_DATA_W;
  localparam int OUT_DATA_W     = kpmh_pkg::OUT_DATA_W;

  localparam int IDLE_PCT      = 17;
  localparam int RANDOM_WORDS  = 188;
  localparam int DRAIN_CYCLES  = kpmh_pkg::NUM_STAGES + 16;
  localparam int REPORT_LIMIT  = 10;
  localparam int MAX_SEQ_LEN   = 16;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;    // [15:0] token
  logic                   in_tlast = 1'b0;  // seq_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;        // [5:0] part_index, [21:6] sig_token
  logic                   out_tlast;        // last_part
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [HASH_W-1:0]      cfg_data = '0;

  logic [HASH_W-1:0] hash_mult_q = HASH_W'(1);
  logic [HASH_W-1:0] hash_add_q = '0;
  logic [HASH_W-1:0] min_hash_q [NUM_PARTITIONS];
  logic [TOK_W-1:0]  best_tok_q [NUM_PARTITIONS];
  kpmh_pkg::kpmh_res_t sig_expect [$];
  int                err_count = 0;
  bit                steady = 1'b0;

  k_partition_minhash_signature dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] token_hash(logic [TOK_W-1:0] tok);
    longint t;
    t = longint'(tok) * longint'(hash_mult_q) + longint'(hash_add_q);
    return HASH_W'((t % kpmh_pkg::HASH_PRIME_L) % kpmh_pkg::HASH_RANGE_L);
  endfunction

  task automatic clear_tables;
    for (int p = 0; p < NUM_PARTITIONS; p++) begin
      min_hash_q[p] = kpmh_pkg::SENTINEL;
      best_tok_q[p] = kpmh_pkg::EMPTY_TOK;
    end
  endtask

  task automatic absorb_token(logic [TOK_W-1:0] tok, logic last);
    logic [HASH_W-1:0] v;
    int part;
    kpmh_pkg::kpmh_res_t r;
    v = token_hash(tok);
    part = int'(longint'(v) / kpmh_pkg::PART_WIDTH_L);
    if (part >= NUM_PARTITIONS) part = NUM_PARTITIONS - 1;
    if (v < min_hash_q[part]) begin
      min_hash_q[part] = v;
      best_tok_q[part] = tok;
    end
    if (last) begin
      for (int p = 0; p < NUM_PARTITIONS; p++) begin
        r.part = PART_W'(p);
        r.tok  = best_tok_q[p];
        r.last = (p == NUM_PARTITIONS - 1);
        sig_expect.push_back(r);
      end
      clear_tables();
    end
  endtask

  task automatic check_word(logic [OUT_DATA_W-1:0] data, logic last);
    kpmh_pkg::kpmh_res_t want;
    logic [OUT_DATA_W-1:0] want_data;
    if (sig_expect.size() == 0) begin
      err_count++;
      if (err_count <= REPORT_LIMIT)
        $display("unexpected word: part %0d token %0d last %0b",
                 data[PART_W-1:0], data[PART_W +: TOK_W], last);
    end else begin
      want = sig_expect.pop_front();
      want_data = OUT_DATA_W'({want.tok, want.part});
      if (data !== want_data || last !== want.last) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("mismatch: exp part %0d tok %0d last %0b, got part %0d tok %0d last %0b",
                   want.part, want.tok, want.last,
                   data[PART_W-1:0], data[PART_W +: TOK_W], last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_word(out_tdata, out_tlast);
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_word(logic [TOK_W-1:0] tok, logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tok;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_token(tok, last);
  endtask

  task automatic wait_for_results;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sig_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HASH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == kpmh_pkg::REG_HASH_MULT) hash_mult_q = data;
    else if (idx == kpmh_pkg::REG_HASH_ADD) hash_add_q = data;
    @(posedge clk);
  endtask

  function automatic logic [HASH_W-1:0] pick_reg_value;
    case ($urandom_range(4))
      0: return HASH_W'($urandom);
      1: return HASH_W'($urandom_range(32'(kpmh_pkg::HASH_PRIME_L - 1)));
      2: return HASH_W'($urandom_range(3));
      3: return HASH_W'(kpmh_pkg::HASH_PRIME_L - 1);
      default: return '1;
    endcase
  endfunction

  function automatic logic [TOK_W-1:0] pick_token;
    case ($urandom_range(3))
      0: return TOK_W'($urandom_range(7));
      1: return TOK_W'($urandom_range(16'hFFFF, VOCAB_SIZE));
      default: return TOK_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(kpmh_pkg::EMPTY_TOK, 1'b0);
    send_word(TOK_W'(VOCAB_SIZE - 1), 1'b0);
    send_word(TOK_W'(1), 1'b1);
    send_word(TOK_W'(7), 1'b1);
  endtask

  task automatic test_tie_keeps_first;
    wait_for_results();
    write_reg(kpmh_pkg::REG_HASH_MULT, '0);
    write_reg(kpmh_pkg::REG_HASH_ADD, HASH_W'(12345));
    send_word(TOK_W'(300), 1'b0);
    send_word(TOK_W'(200), 1'b0);
    send_word(TOK_W'(300), 1'b0);
    send_word('1, 1'b1);
  endtask

  task automatic test_register_extremes;
    wait_for_results();
    write_reg(kpmh_pkg::REG_HASH_MULT, '1);
    write_reg(kpmh_pkg::REG_HASH_ADD, '1);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(TOK_W'(1), 1'b1);
    wait_for_results();
    // prime minus one wraps to hash zero after the range reduction
    write_reg(kpmh_pkg::REG_HASH_MULT, HASH_W'(kpmh_pkg::HASH_PRIME_L - 1));
    write_reg(kpmh_pkg::REG_HASH_ADD, HASH_W'(kpmh_pkg::HASH_PRIME_L - 1));
    send_word('0, 1'b0);
    send_word(TOK_W'(2), 1'b1);
  endtask

  task automatic test_ignored_index;
    wait_for_results();
    write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, kpmh_pkg::REG_HASH_ADD + 1)),
              HASH_W'($urandom));
    send_word(TOK_W'(5), 1'b0);
    send_word(TOK_W'(9), 1'b1);
  endtask

  task automatic test_random_sequences;
    int sent;
    int seq_len;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(3) == 0) begin
        steady = 1'b0;
        wait_for_results();
        if ($urandom_range(1)) write_reg(kpmh_pkg::REG_HASH_MULT, pick_reg_value());
        if ($urandom_range(1)) write_reg(kpmh_pkg::REG_HASH_ADD, pick_reg_value());
        if ($urandom_range(7) == 0)
          write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1,
                                              kpmh_pkg::REG_HASH_ADD + 1)),
                    HASH_W'($urandom));
      end
      steady = (sent >= 80 && sent < 130);
      seq_len = ($urandom_range(4) == 0) ? 1 : $urandom_range(MAX_SEQ_LEN, 2);
      for (int i = 0; i < seq_len; i++) begin
        send_word(pick_token(), i == seq_len - 1);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    clear_tables();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_tie_keeps_first();
    test_register_extremes();
    test_ignored_index();
    test_random_sequences();
    wait_for_results();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
